// ===== hw/rtl/fcdt_pkg.sv =====
package fcdt_pkg;

   // table size default
   localparam int ENTRIES_DEF = 16;

   // register reset values and saturation limits
   localparam logic [15:0] HEARTBEAT_RST = 16'd1000;
   localparam logic [7:0]  OCC_MAX       = 8'd255;
   localparam logic [15:0] DETECT_MAX    = 16'hFFFF;

   // request actions
   localparam logic [2:0] ACT_REPORT  = 3'd0;
   localparam logic [2:0] ACT_PROCESS = 3'd1;
   localparam logic [2:0] ACT_READ    = 3'd2;
   localparam logic [2:0] ACT_SENT    = 3'd3;
   localparam logic [2:0] ACT_CLEAR   = 3'd4;
   localparam logic [2:0] ACT_DEFINE  = 3'd5;

   // configuration register indexes
   localparam logic [1:0] CSR_ENTRY_COUNT = 2'd0;
   localparam logic [1:0] CSR_HEARTBEAT   = 2'd1;

   // status bit positions
   localparam int ST_FAILED    = 0;
   localparam int ST_PENDING   = 1;
   localparam int ST_CONFIRMED = 2;
   localparam int ST_WARNING   = 3;

   // definition and raw level record
   typedef struct packed {
      logic        raw_level;
      logic [31:0] raw_time;
      logic [31:0] confirm;
      logic [31:0] heal;
      logic        warning;
      logic [15:0] code;
   } def_rec_type;

   // per-entry debounce result record
   typedef struct packed {
      logic [3:0]  status;
      logic [7:0]  occurrence;
      logic [31:0] first_time;
      logic [31:0] last_time;
      logic [15:0] detect;
   } ent_rec_type;

endpackage

// ===== hw/rtl/fcdt_if.sv =====
interface fcdt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [3:0]  index;
   logic        failed;
   logic [31:0] now;
   logic [31:0] confirm_time;
   logic [31:0] heal_ms;
   logic        warning;
   logic [15:0] code;

   modport source (output valid, action, index, failed, now, confirm_time, heal_ms, warning,
                   code, input ready);
   modport sink (input valid, action, index, failed, now, confirm_time, heal_ms, warning,
                 code, output ready);
endinterface

interface fcdt_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [7:0]  occurrence;
   logic [31:0] first_time;
   logic [31:0] last_time;
   logic [15:0] detect_delay;
   logic [4:0]  active_count;
   logic [4:0]  confirmed_count;
   logic        send_due;
   logic [31:0] sequence_res;
   logic        capture_valid;
   logic [15:0] capture_code;
   logic [31:0] capture_time;

   modport source (output valid, status, occurrence, first_time, last_time, detect_delay,
                   active_count, confirmed_count, send_due, sequence_res, capture_valid,
                   capture_code, capture_time, input ready);
   modport sink (input valid, status, occurrence, first_time, last_time, detect_delay,
                 active_count, confirmed_count, send_due, sequence_res, capture_valid,
                 capture_code, capture_time, output ready);
endinterface

interface fcdt_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/fault_code_debounce_table.sv =====
// Fault code debounce table. Each request returns exactly one response. Report, read,
// notify-sent, clear and define requests pass through the execute state and then the
// finish state; a process request walks the entries in use through the two entry
// memories, one entry per cycle, and then enters the finish state. The finish state
// loads the response register, waiting while an earlier response has not been taken.
// One request is handled at a time; a new request is accepted once the previous one has
// reached the response register, even while that response still waits to be taken. Both
// memories have registered reads; per-entry valid flags make never-written entries read
// as zero, so no clearing pass is needed and clear-all takes effect at once. Configuration
// writes are always accepted and must only be issued while the block is idle.
module fault_code_debounce_table
   import fcdt_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   fcdt_req_if.sink  req_if,
   fcdt_rsp_if.source rsp_if,
   fcdt_csr_if.sink  csr_if
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int EC_W  = ($clog2(ENTRIES + 1) > 5) ? $clog2(ENTRIES + 1) : 5;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WALK, S_FIN} state_type;

   state_type state_ff;

   // configuration
   logic [EC_W-1:0] entry_count_ff;
   logic [15:0]     heartbeat_ff;

   // global state
   logic [31:0]      seq_ff;
   logic [31:0]      last_send_ff;
   logic             dirty_ff;
   logic             cap_valid_ff;
   logic [15:0]      cap_code_ff;
   logic [31:0]      cap_time_ff;
   logic [CNT_W-1:0] cnt_act_ff;
   logic [CNT_W-1:0] cnt_conf_ff;
   logic [CNT_W-1:0] acc_act_ff;
   logic [CNT_W-1:0] acc_conf_ff;
   logic [IDX_W-1:0] walk_ff;

   // latched request
   logic [2:0]  op_action_ff;
   logic [3:0]  op_index_ff;
   logic        op_failed_ff;
   logic [31:0] op_now_ff;
   logic [31:0] op_confirm_ff;
   logic [31:0] op_heal_ff;
   logic        op_warning_ff;
   logic [15:0] op_code_ff;

   // memories and their valid flags
   def_rec_type mem_a [ENTRIES];
   ent_rec_type mem_b [ENTRIES];
   logic [ENTRIES-1:0] a_vld_ff;
   logic [ENTRIES-1:0] b_vld_ff;
   def_rec_type a_rd_ff;
   ent_rec_type b_rd_ff;
   logic        a_rdv_ff;
   logic        b_rdv_ff;

   // response register
   logic        rsp_valid_ff;
   logic [3:0]  rsp_status_ff;
   logic [7:0]  rsp_occ_ff;
   logic [31:0] rsp_first_ff;
   logic [31:0] rsp_last_ff;
   logic [15:0] rsp_det_ff;
   logic [4:0]  rsp_act_ff;
   logic [4:0]  rsp_conf_ff;
   logic        rsp_due_ff;
   logic [31:0] rsp_seq_ff;
   logic        rsp_capv_ff;
   logic [15:0] rsp_capc_ff;
   logic [31:0] rsp_capt_ff;

   logic             req_acc;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W+3:0] req_idx_wide;
   logic [IDX_W+3:0] op_idx_wide;
   logic [IDX_W-1:0] op_addr;
   logic             in_use;
   logic             def_ok;
   logic             walk_last;
   def_rec_type      a_cur;
   ent_rec_type      b_cur;
   logic             a_we;
   logic             b_we;
   logic [IDX_W-1:0] wr_addr;
   def_rec_type      a_wd;
   ent_rec_type      b_wd;
   logic [31:0]      held;
   logic [3:0]       nst;
   logic             cap_take;
   logic             rsp_free;
   logic             send_due;
   logic [CNT_W+4:0] act_ext;
   logic [CNT_W+4:0] conf_ext;
   logic [4:0]       csr_cnt;

   // handshakes
   assign req_if.ready = (state_ff == S_IDLE);
   assign csr_if.ready = 1'b1;
   assign req_acc      = req_if.valid && (state_ff == S_IDLE);
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;

   // entry addressing
   assign req_idx_wide = {{IDX_W{1'b0}}, req_if.index};
   assign op_idx_wide  = {{IDX_W{1'b0}}, op_index_ff};
   assign op_addr      = op_idx_wide[IDX_W-1:0];
   assign in_use       = EC_W'(op_index_ff) < entry_count_ff;
   assign def_ok       = 32'(op_index_ff) < ENTRIES;
   assign walk_last    = (EC_W'(walk_ff) + EC_W'(1)) == entry_count_ff;

   // memory read port control
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = op_addr;
      if (req_acc) begin
         rd_en   = 1'b1;
         rd_addr = (req_if.action == ACT_PROCESS) ? '0 : req_idx_wide[IDX_W-1:0];
      end else if (state_ff == S_WALK && !walk_last) begin
         rd_en   = 1'b1;
         rd_addr = walk_ff + IDX_W'(1);
      end
   end

   // never-written entries read as zero
   assign a_cur = a_rdv_ff ? a_rd_ff : '0;
   assign b_cur = b_rdv_ff ? b_rd_ff : '0;
   assign held  = op_now_ff - a_cur.raw_time;

   // debounce of one entry during the walk, and the last-time update of a report
   always_comb begin
      nst      = b_cur.status;
      cap_take = 1'b0;
      b_wd     = b_cur;
      b_wd.status = b_cur.status;
      if (a_cur.raw_level) begin
         if (!b_cur.status[ST_FAILED]) begin
            if (held >= a_cur.confirm) begin
               nst[ST_CONFIRMED] = 1'b1;
               nst[ST_FAILED]    = 1'b1;
               nst[ST_PENDING]   = 1'b0;
               if (a_cur.warning) begin
                  nst[ST_WARNING] = 1'b1;
               end
               if (b_cur.occurrence == '0) begin
                  b_wd.first_time = op_now_ff;
               end
               if (b_cur.occurrence != OCC_MAX) begin
                  b_wd.occurrence = b_cur.occurrence + 8'd1;
               end
               b_wd.detect = (held > 32'(DETECT_MAX)) ? DETECT_MAX : held[15:0];
               cap_take    = !cap_valid_ff;
            end else begin
               nst[ST_PENDING] = 1'b1;
            end
         end
      end else begin
         nst[ST_PENDING] = 1'b0;
         if (b_cur.status[ST_FAILED] && held >= a_cur.heal) begin
            nst[ST_FAILED]  = 1'b0;
            nst[ST_WARNING] = 1'b0;
         end
      end
      if (state_ff == S_WALK) begin
         b_wd.status = nst;
      end else if (state_ff == S_EXEC && op_action_ff == ACT_REPORT) begin
         b_wd = b_cur;
         b_wd.last_time = op_now_ff;
      end
   end

   // memory write port control
   always_comb begin
      a_we    = 1'b0;
      b_we    = 1'b0;
      wr_addr = op_addr;
      a_wd    = a_cur;
      if (state_ff == S_WALK) begin
         b_we    = 1'b1;
         wr_addr = walk_ff;
      end else if (state_ff == S_EXEC) begin
         case (op_action_ff)
            ACT_REPORT: begin
               a_we = in_use;
               b_we = in_use && op_failed_ff;
               if (op_failed_ff != a_cur.raw_level) begin
                  a_wd.raw_level = op_failed_ff;
                  a_wd.raw_time  = op_now_ff;
               end
            end
            ACT_DEFINE: begin
               a_we         = def_ok;
               a_wd.confirm = op_confirm_ff;
               a_wd.heal    = op_heal_ff;
               a_wd.warning = op_warning_ff;
               a_wd.code    = op_code_ff;
            end
            default: begin
               a_we = 1'b0;
            end
         endcase
      end
   end

   // entry memories
   always_ff @(posedge clock) begin
      if (a_we) begin
         mem_a[wr_addr] <= a_wd;
      end
      if (b_we) begin
         mem_b[wr_addr] <= b_wd;
      end
      if (rd_en) begin
         a_rd_ff  <= mem_a[rd_addr];
         b_rd_ff  <= mem_b[rd_addr];
         a_rdv_ff <= a_vld_ff[rd_addr];
         b_rdv_ff <= b_vld_ff[rd_addr];
      end
   end

   // response values
   assign send_due = dirty_ff || ((op_now_ff - last_send_ff) >= {16'd0, heartbeat_ff});
   assign act_ext  = {5'd0, cnt_act_ff};
   assign conf_ext = {5'd0, cnt_conf_ff};
   assign csr_cnt  = csr_if.data[4:0];

   // sequencer, global state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         entry_count_ff <= EC_W'(ENTRIES);
         heartbeat_ff   <= HEARTBEAT_RST;
         seq_ff         <= '0;
         last_send_ff   <= '0;
         dirty_ff       <= 1'b1;
         cap_valid_ff   <= 1'b0;
         cap_code_ff    <= '0;
         cap_time_ff    <= '0;
         cnt_act_ff     <= '0;
         cnt_conf_ff    <= '0;
         acc_act_ff     <= '0;
         acc_conf_ff    <= '0;
         walk_ff        <= '0;
         a_vld_ff       <= '0;
         b_vld_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         // configuration writes
         if (csr_if.valid) begin
            if (csr_if.index == CSR_ENTRY_COUNT && csr_cnt != 5'd0) begin
               entry_count_ff <= (32'(csr_cnt) > ENTRIES) ? EC_W'(ENTRIES) : EC_W'(csr_cnt);
            end else if (csr_if.index == CSR_HEARTBEAT) begin
               heartbeat_ff <= csr_if.data;
            end
         end

         if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (a_we) begin
            a_vld_ff[wr_addr] <= 1'b1;
         end
         if (b_we) begin
            b_vld_ff[wr_addr] <= 1'b1;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  op_action_ff  <= req_if.action;
                  op_index_ff   <= req_if.index;
                  op_failed_ff  <= req_if.failed;
                  op_now_ff     <= req_if.now;
                  op_confirm_ff <= req_if.confirm_time;
                  op_heal_ff    <= req_if.heal_ms;
                  op_warning_ff <= req_if.warning;
                  op_code_ff    <= req_if.code;
                  walk_ff       <= '0;
                  acc_act_ff    <= '0;
                  acc_conf_ff   <= '0;
                  state_ff      <= (req_if.action == ACT_PROCESS) ? S_WALK : S_EXEC;
               end
            end
            S_EXEC: begin
               case (op_action_ff)
                  ACT_SENT: begin
                     seq_ff       <= seq_ff + 32'd1;
                     last_send_ff <= op_now_ff;
                     dirty_ff     <= 1'b0;
                  end
                  ACT_CLEAR: begin
                     b_vld_ff     <= '0;
                     cap_valid_ff <= 1'b0;
                     cap_code_ff  <= '0;
                     cap_time_ff  <= '0;
                     cnt_act_ff   <= '0;
                     cnt_conf_ff  <= '0;
                     dirty_ff     <= 1'b1;
                  end
                  default: begin
                     dirty_ff <= dirty_ff;
                  end
               endcase
               state_ff <= S_FIN;
            end
            S_WALK: begin
               if (cap_take) begin
                  cap_valid_ff <= 1'b1;
                  cap_code_ff  <= a_cur.code;
                  cap_time_ff  <= op_now_ff;
               end
               if (nst != b_cur.status) begin
                  dirty_ff <= 1'b1;
               end
               acc_act_ff  <= acc_act_ff + CNT_W'(nst[ST_FAILED]);
               acc_conf_ff <= acc_conf_ff + CNT_W'(nst[ST_CONFIRMED]);
               walk_ff     <= walk_ff + IDX_W'(1);
               if (walk_last) begin
                  cnt_act_ff  <= acc_act_ff + CNT_W'(nst[ST_FAILED]);
                  cnt_conf_ff <= acc_conf_ff + CNT_W'(nst[ST_CONFIRMED]);
                  state_ff    <= S_FIN;
               end
            end
            S_FIN: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (state_ff == S_FIN && rsp_free) begin
         if (op_action_ff == ACT_READ && in_use) begin
            rsp_status_ff <= b_cur.status;
            rsp_occ_ff    <= b_cur.occurrence;
            rsp_first_ff  <= b_cur.first_time;
            rsp_last_ff   <= b_cur.last_time;
            rsp_det_ff    <= b_cur.detect;
         end else begin
            rsp_status_ff <= '0;
            rsp_occ_ff    <= '0;
            rsp_first_ff  <= '0;
            rsp_last_ff   <= '0;
            rsp_det_ff    <= '0;
         end
         rsp_act_ff  <= act_ext[4:0];
         rsp_conf_ff <= conf_ext[4:0];
         rsp_due_ff  <= send_due;
         rsp_seq_ff  <= seq_ff;
         rsp_capv_ff <= cap_valid_ff;
         rsp_capc_ff <= cap_code_ff;
         rsp_capt_ff <= cap_time_ff;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.status          = rsp_status_ff;
   assign rsp_if.occurrence      = rsp_occ_ff;
   assign rsp_if.first_time      = rsp_first_ff;
   assign rsp_if.last_time       = rsp_last_ff;
   assign rsp_if.detect_delay    = rsp_det_ff;
   assign rsp_if.active_count    = rsp_act_ff;
   assign rsp_if.confirmed_count = rsp_conf_ff;
   assign rsp_if.send_due        = rsp_due_ff;
   assign rsp_if.sequence_res    = rsp_seq_ff;
   assign rsp_if.capture_valid   = rsp_capv_ff;
   assign rsp_if.capture_code    = rsp_capc_ff;
   assign rsp_if.capture_time    = rsp_capt_ff;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import fcdt_pkg::*;

   localparam int NUM_ENTRIES = 16;
   localparam int IDLE_LIMIT  = 2000;

   typedef struct {
      logic [2:0]  action;
      logic [3:0]  index;
      logic        failed;
      logic [31:0] now;
      logic [31:0] confirm_time;
      logic [31:0] heal_ms;
      logic        warning;
      logic [15:0] code;
      bit          drain_first;
   } fault_req_type;

   typedef struct {
      logic [3:0]  status;
      logic [7:0]  occurrence;
      logic [31:0] first_time;
      logic [31:0] last_time;
      logic [15:0] detect_delay;
      logic [4:0]  active_count;
      logic [4:0]  confirmed_count;
      logic        send_due;
      logic [31:0] sequence_res;
      logic        capture_valid;
      logic [15:0] capture_code;
      logic [31:0] capture_time;
   } fault_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fcdt_req_if req_bus ();
   fcdt_rsp_if rsp_bus ();
   fcdt_csr_if csr_bus ();

   fault_code_debounce_table #(.ENTRIES(NUM_ENTRIES)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always #6 clock = ~clock;

   // pending requests and expected responses
   fault_req_type pending_reqs[$];
   fault_rsp_type expected_rsps[$];
   int            mismatches = 0;
   int            idle_cycles = 0;

   // debounce table shadow
   int unsigned tbl_count;
   logic [15:0] tbl_heartbeat;
   logic        raw_lvl     [NUM_ENTRIES];
   logic [31:0] raw_time    [NUM_ENTRIES];
   logic [3:0]  ent_status  [NUM_ENTRIES];
   logic [7:0]  ent_occ     [NUM_ENTRIES];
   logic [31:0] ent_first   [NUM_ENTRIES];
   logic [31:0] ent_last    [NUM_ENTRIES];
   logic [15:0] ent_detect  [NUM_ENTRIES];
   logic [31:0] def_confirm [NUM_ENTRIES];
   logic [31:0] def_heal    [NUM_ENTRIES];
   logic        def_warn    [NUM_ENTRIES];
   logic [15:0] def_code    [NUM_ENTRIES];
   logic [31:0] send_seq;
   logic [31:0] last_send;
   logic        dirty;
   logic        cap_valid;
   logic [15:0] cap_code;
   logic [31:0] cap_time;
   logic [4:0]  cnt_active;
   logic [4:0]  cnt_confirmed;

   function automatic void clear_table();
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         ent_status[i] = '0;
         ent_occ[i]    = '0;
         ent_first[i]  = '0;
         ent_last[i]   = '0;
         ent_detect[i] = '0;
      end
      cap_valid     = 1'b0;
      cap_code      = '0;
      cap_time      = '0;
      cnt_active    = '0;
      cnt_confirmed = '0;
      dirty         = 1'b1;
   endfunction

   function automatic void reset_table();
      tbl_count     = NUM_ENTRIES;
      tbl_heartbeat = HEARTBEAT_RST;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         raw_lvl[i]     = 1'b0;
         raw_time[i]    = '0;
         def_confirm[i] = '0;
         def_heal[i]    = '0;
         def_warn[i]    = 1'b0;
         def_code[i]    = '0;
      end
      clear_table();
      send_seq  = '0;
      last_send = '0;
   endfunction

   function automatic void csr_update(logic [1:0] idx, logic [15:0] data);
      if (idx == CSR_ENTRY_COUNT) begin
         if (data[4:0] != 0)
            tbl_count = (data[4:0] > NUM_ENTRIES) ? NUM_ENTRIES : data[4:0];
      end else if (idx == CSR_HEARTBEAT) begin
         tbl_heartbeat = data;
      end
   endfunction

   // walk every entry in use and debounce it
   function automatic void debounce_pass(logic [31:0] now);
      logic [31:0] held;
      logic [3:0]  old_st;
      logic [3:0]  st;
      logic [4:0]  act;
      logic [4:0]  conf;
      act  = '0;
      conf = '0;
      for (int i = 0; i < tbl_count; i++) begin
         held   = now - raw_time[i];
         old_st = ent_status[i];
         st     = old_st;
         if (raw_lvl[i]) begin
            if (!st[ST_FAILED]) begin
               if (held >= def_confirm[i]) begin
                  st[ST_CONFIRMED] = 1'b1;
                  st[ST_FAILED]    = 1'b1;
                  st[ST_PENDING]   = 1'b0;
                  if (def_warn[i])
                     st[ST_WARNING] = 1'b1;
                  if (ent_occ[i] == 0)
                     ent_first[i] = now;
                  if (ent_occ[i] != OCC_MAX)
                     ent_occ[i] = ent_occ[i] + 1;
                  ent_detect[i] = (held > DETECT_MAX) ? DETECT_MAX : held[15:0];
                  if (!cap_valid) begin
                     cap_valid = 1'b1;
                     cap_code  = def_code[i];
                     cap_time  = now;
                  end
               end else begin
                  st[ST_PENDING] = 1'b1;
               end
            end
         end else begin
            st[ST_PENDING] = 1'b0;
            if (st[ST_FAILED] && held >= def_heal[i]) begin
               st[ST_FAILED]  = 1'b0;
               st[ST_WARNING] = 1'b0;
            end
         end
         ent_status[i] = st;
         if (st != old_st)
            dirty = 1'b1;
         if (st[ST_FAILED])
            act++;
         if (st[ST_CONFIRMED])
            conf++;
      end
      cnt_active    = act;
      cnt_confirmed = conf;
   endfunction

   // apply one accepted request and queue its response
   function automatic void predict_response(fault_req_type rq);
      fault_rsp_type rs;
      logic [31:0] since;
      bit in_use;
      in_use = rq.index < tbl_count;
      rs.status       = '0;
      rs.occurrence   = '0;
      rs.first_time   = '0;
      rs.last_time    = '0;
      rs.detect_delay = '0;
      case (rq.action)
         ACT_REPORT: begin
            if (in_use) begin
               if (rq.failed != raw_lvl[rq.index]) begin
                  raw_lvl[rq.index]  = rq.failed;
                  raw_time[rq.index] = rq.now;
               end
               if (rq.failed)
                  ent_last[rq.index] = rq.now;
            end
         end
         ACT_PROCESS: debounce_pass(rq.now);
         ACT_READ: begin
            if (in_use) begin
               rs.status       = ent_status[rq.index];
               rs.occurrence   = ent_occ[rq.index];
               rs.first_time   = ent_first[rq.index];
               rs.last_time    = ent_last[rq.index];
               rs.detect_delay = ent_detect[rq.index];
            end
         end
         ACT_SENT: begin
            send_seq  = send_seq + 1;
            last_send = rq.now;
            dirty     = 1'b0;
         end
         ACT_CLEAR: clear_table();
         ACT_DEFINE: begin
            def_confirm[rq.index] = rq.confirm_time;
            def_heal[rq.index]    = rq.heal_ms;
            def_warn[rq.index]    = rq.warning;
            def_code[rq.index]    = rq.code;
         end
         default: ;
      endcase
      since = rq.now - last_send;
      rs.active_count    = cnt_active;
      rs.confirmed_count = cnt_confirmed;
      rs.send_due        = dirty || (since >= {16'd0, tbl_heartbeat});
      rs.sequence_res    = send_seq;
      rs.capture_valid   = cap_valid;
      rs.capture_code    = cap_code;
      rs.capture_time    = cap_time;
      expected_rsps.push_back(rs);
   endfunction

   // request driver
   int            req_gap = 0;
   fault_req_type req_cur;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !req_bus.ready) begin
         req_bus.valid <= 1'b1;
      end else begin
         if (req_bus.valid) begin
            predict_response(req_cur);
            req_gap = $urandom_range(0, 3);
         end
         if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_reqs.size() > 0 && !(pending_reqs[0].drain_first
                      && (expected_rsps.size() > 0 || req_bus.valid))) begin
            req_cur = pending_reqs.pop_front();
            req_bus.action       <= req_cur.action;
            req_bus.index        <= req_cur.index;
            req_bus.failed       <= req_cur.failed;
            req_bus.now          <= req_cur.now;
            req_bus.confirm_time <= req_cur.confirm_time;
            req_bus.heal_ms      <= req_cur.heal_ms;
            req_bus.warning      <= req_cur.warning;
            req_bus.code         <= req_cur.code;
            req_bus.valid        <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         mismatches++;
      end
   endfunction

   // response monitor with random stalls
   int rsp_stall = 0;

   always @(posedge clock) begin
      fault_rsp_type e;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rsps.size() == 0) begin
               $error("response with no request outstanding");
               mismatches++;
            end else begin
               e = expected_rsps.pop_front();
               check_field("status", e.status, rsp_bus.status);
               check_field("occurrence", e.occurrence, rsp_bus.occurrence);
               check_field("first_time", e.first_time, rsp_bus.first_time);
               check_field("last_time", e.last_time, rsp_bus.last_time);
               check_field("detect_delay", e.detect_delay, rsp_bus.detect_delay);
               check_field("active_count", e.active_count, rsp_bus.active_count);
               check_field("confirmed_count", e.confirmed_count, rsp_bus.confirmed_count);
               check_field("send_due", e.send_due, rsp_bus.send_due);
               check_field("sequence_res", e.sequence_res, rsp_bus.sequence_res);
               check_field("capture_valid", e.capture_valid, rsp_bus.capture_valid);
               check_field("capture_code", e.capture_code, rsp_bus.capture_code);
               check_field("capture_time", e.capture_time, rsp_bus.capture_time);
            end
            rsp_stall = $urandom_range(0, 3);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic fault_req_type make_req(logic [2:0] action, logic [3:0] index,
                                              logic failed, logic [31:0] now);
      fault_req_type rq;
      rq.action       = action;
      rq.index        = index;
      rq.failed       = failed;
      rq.now          = now;
      rq.confirm_time = $urandom;
      rq.heal_ms      = $urandom;
      rq.warning      = $urandom_range(0, 1);
      rq.code         = $urandom;
      rq.drain_first  = 1'b0;
      return rq;
   endfunction

   function automatic fault_req_type make_define(logic [3:0] index, logic [31:0] confirm,
                                                 logic [31:0] heal, logic warning,
                                                 logic [15:0] code);
      fault_req_type rq;
      rq = make_req(ACT_DEFINE, index, $urandom_range(0, 1), $urandom);
      rq.confirm_time = confirm;
      rq.heal_ms      = heal;
      rq.warning      = warning;
      rq.code         = code;
      return rq;
   endfunction

   function automatic logic [31:0] pick_debounce();
      case ($urandom_range(0, 19))
         0:       return 32'hFFFF_FFFF;
         1:       return 32'd0;
         2:       return $urandom;
         3:       return 32'd70000 + $urandom_range(0, 1000);
         default: return $urandom_range(1, 40);
      endcase
   endfunction

   task automatic csr_write(logic [1:0] idx, logic [15:0] data);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      csr_update(idx, data);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_reqs.size() > 0 || req_bus.valid || expected_rsps.size() > 0);
      repeat (NUM_ENTRIES + 8) @(posedge clock);
   endtask

   // table exercise with random debounce sequences, including undefined action codes
   task automatic random_phase(int n_items);
      logic [31:0]   t;
      fault_req_type rq;
      int            pick;
      t = $urandom;
      for (int i = 0; i < NUM_ENTRIES; i++)
         pending_reqs.push_back(make_define(i, pick_debounce(), pick_debounce(),
                                            $urandom_range(0, 1), $urandom));
      for (int n = 0; n < n_items; n++) begin
         if ($urandom_range(0, 19) == 0)
            t = $urandom;
         else
            t = t + $urandom_range(0, 20);
         pick = $urandom_range(0, 99);
         if (pick < 35)
            rq = make_req(ACT_REPORT, $urandom_range(0, 15), $urandom_range(0, 1), t);
         else if (pick < 60)
            rq = make_req(ACT_PROCESS, $urandom_range(0, 15), $urandom_range(0, 1), t);
         else if (pick < 80)
            rq = make_req(ACT_READ, $urandom_range(0, 15), $urandom_range(0, 1), t);
         else if (pick < 86)
            rq = make_req(ACT_SENT, $urandom_range(0, 15), $urandom_range(0, 1), t);
         else if (pick < 88)
            rq = make_req(ACT_CLEAR, $urandom_range(0, 15), $urandom_range(0, 1), t);
         else if (pick < 95)
            rq = make_define($urandom_range(0, 15), pick_debounce(), pick_debounce(),
                             $urandom_range(0, 1), $urandom);
         else
            rq = make_req($urandom_range(6, 7), $urandom_range(0, 15),
                          $urandom_range(0, 1), t);
         if (n == n_items / 2)
            rq.drain_first = 1'b1;
         pending_reqs.push_back(rq);
      end
      wait_idle();
   endtask

   initial begin
      req_bus.valid        = 1'b0;
      req_bus.action       = '0;
      req_bus.index        = '0;
      req_bus.failed       = 1'b0;
      req_bus.now          = '0;
      req_bus.confirm_time = '0;
      req_bus.heal_ms      = '0;
      req_bus.warning      = 1'b0;
      req_bus.code         = '0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = '0;
      csr_bus.data         = '0;
      reset_table();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: read before define, immediate confirm and heal, saturation, misc
      pending_reqs.push_back(make_req(ACT_READ, 0, 0, 0));
      pending_reqs.push_back(make_define(0, 0, 0, 1, 16'hFFFF));
      pending_reqs.push_back(make_req(ACT_REPORT, 0, 1, 5));
      pending_reqs.push_back(make_req(ACT_PROCESS, 0, 0, 5));
      pending_reqs.push_back(make_req(ACT_READ, 0, 0, 6));
      pending_reqs.push_back(make_req(ACT_REPORT, 0, 0, 7));
      pending_reqs.push_back(make_req(ACT_PROCESS, 0, 0, 7));
      pending_reqs.push_back(make_req(ACT_READ, 0, 0, 8));
      pending_reqs.push_back(make_define(15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 16'h0000));
      pending_reqs.push_back(make_define(3, 100000, 5, 0, 16'h1234));
      pending_reqs.push_back(make_req(ACT_REPORT, 3, 1, 10));
      pending_reqs.push_back(make_req(ACT_REPORT, 15, 1, 10));
      pending_reqs.push_back(make_req(ACT_PROCESS, 0, 0, 50));
      pending_reqs.push_back(make_req(ACT_PROCESS, 0, 0, 120000));
      pending_reqs.push_back(make_req(ACT_READ, 3, 0, 120000));
      pending_reqs.push_back(make_req(ACT_READ, 15, 0, 120001));
      pending_reqs.push_back(make_req(ACT_SENT, 0, 0, 32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(ACT_READ, 0, 0, 32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(ACT_READ, 0, 0, 998));
      pending_reqs.push_back(make_req(ACT_CLEAR, 0, 0, 1000));
      pending_reqs.push_back(make_req(ACT_READ, 3, 0, 1001));
      pending_reqs.push_back(make_req(3'd6, 9, 1, 1002));
      pending_reqs.push_back(make_req(3'd7, 9, 1, 1003));
      wait_idle();

      random_phase(170);
      csr_write(CSR_ENTRY_COUNT, 16'd1);
      csr_write(CSR_HEARTBEAT, 16'd0);
      random_phase(150);
      csr_write(CSR_ENTRY_COUNT, 16'd0);
      csr_write(CSR_HEARTBEAT, 16'hFFFF);
      random_phase(150);
      csr_write(CSR_ENTRY_COUNT, 16'hFFFF);
      csr_write(CSR_HEARTBEAT, 16'd1);
      random_phase(180);
      csr_write(CSR_ENTRY_COUNT, 16'd5);
      csr_write(CSR_HEARTBEAT, 16'd30);
      random_phase(170);
      csr_write(CSR_ENTRY_COUNT, 16'd16);
      csr_write(CSR_HEARTBEAT, 16'd1000);
      random_phase(150);

      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== fault_code_debounce_table.f =====
hw/rtl/fcdt_pkg.sv
hw/rtl/fcdt_if.sv
hw/rtl/fault_code_debounce_table.sv
test/testbench.sv
